FILE: rtl/sine_cosine_turn_lut_core_defines.svh
// Assertion macros shared by the sine/cosine table core.
// Included by the RTL files that carry concurrent checks; needs a clk and rst_n in scope.
`ifndef SINE_COSINE_TURN_LUT_CORE_DEFINES_SVH
`define SINE_COSINE_TURN_LUT_CORE_DEFINES_SVH

// Check a property on the rising clock edge, skipped while reset is asserted.
`define SCTL_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on the rising clock edge at all times, reset included.
`define SCTL_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: rtl/sctl_pkg.sv
// Types, constants and the quarter-wave sine table for the sine/cosine table core.
// No dependencies; used by sctl_phase and sine_cosine_turn_lut_core.
`default_nettype none

package sctl_pkg;

    typedef logic [15:0]        angle_t;
    typedef logic signed [17:0] sample_t;
    typedef logic [16:0]        rom_word_t;
    typedef logic [6:0]         rom_index_t;

    // Quarter turn on the angle scale, and as a 15-bit mirror position
    localparam angle_t        QUARTER_ANGLE = 16'h4000;
    localparam logic [14:0]   QUARTER_POS   = 15'h4000;
    localparam int            FRAC_SHIFT    = 14;
    localparam rom_index_t    ROM_LAST      = 7'd64;
    localparam sample_t       FULL_SCALE    = 18'sd65536;

    // One quarter wave of sine, unsigned Q1.16, 64 segments plus the end point
    localparam rom_word_t QUARTER_ROM [0:64] = '{
        17'd0,     17'd1608,  17'd3216,  17'd4821,  17'd6424,  17'd8022,  17'd9616,  17'd11204,
        17'd12785, 17'd14359, 17'd15924, 17'd17479, 17'd19024, 17'd20557, 17'd22078, 17'd23586,
        17'd25080, 17'd26558, 17'd28020, 17'd29466, 17'd30893, 17'd32303, 17'd33692, 17'd35062,
        17'd36410, 17'd37736, 17'd39040, 17'd40320, 17'd41576, 17'd42806, 17'd44011, 17'd45190,
        17'd46341, 17'd47464, 17'd48559, 17'd49624, 17'd50660, 17'd51665, 17'd52639, 17'd53581,
        17'd54491, 17'd55368, 17'd56212, 17'd57022, 17'd57798, 17'd58538, 17'd59244, 17'd59914,
        17'd60547, 17'd61145, 17'd61705, 17'd62228, 17'd62714, 17'd63162, 17'd63572, 17'd63944,
        17'd64277, 17'd64571, 17'd64827, 17'd65043, 17'd65220, 17'd65358, 17'd65457, 17'd65516,
        17'd65536
    };

endpackage

`default_nettype wire

FILE: rtl/sctl_phase.sv
// Sine of one 16-bit turn angle: quadrant fold, table read, linear interpolation, sign.
// Depends on sctl_pkg for the table, types and constants.
`default_nettype none

module sctl_phase (
    input  wire sctl_pkg::angle_t  angle,
    output sctl_pkg::sample_t      value
);

    logic [1:0]           quad;
    logic [14:0]          pos;
    logic [5:0]           row;
    sctl_pkg::rom_index_t lo_idx;
    sctl_pkg::rom_index_t hi_idx;
    sctl_pkg::rom_word_t  lo;
    sctl_pkg::rom_word_t  hi;
    sctl_pkg::rom_word_t  diff;
    logic [13:0]          weight;
    logic [30:0]          prod;
    sctl_pkg::rom_word_t  interp;
    sctl_pkg::rom_word_t  mag;

    // Fold the angle into a quarter-wave position, mirrored in odd quadrants
    always_comb
    begin
        quad = angle[15:14];
        if (quad[0])
            pos = sctl_pkg::QUARTER_POS - {1'b0, angle[13:0]};
        else
            pos = {1'b0, angle[13:0]};
    end

    // Read the two neighboring entries and blend them by the low offset bits
    always_comb
    begin
        row    = pos[13:8];
        lo_idx = {1'b0, row};
        hi_idx = lo_idx + 7'd1;
        lo     = sctl_pkg::QUARTER_ROM[lo_idx];
        hi     = sctl_pkg::QUARTER_ROM[hi_idx];
        diff   = hi - lo;
        weight = {pos[7:0], 6'b0};
        prod   = 31'(diff) * 31'(weight);
        interp = lo + prod[30:sctl_pkg::FRAC_SHIFT];
    end

    // Take the end point at a full quarter, then negate the lower half-turn
    always_comb
    begin
        if (pos[14])
            mag = sctl_pkg::QUARTER_ROM[sctl_pkg::ROM_LAST];
        else
            mag = interp;
        if (quad[1])
            value = -sctl_pkg::sample_t'({1'b0, mag});
        else
            value = sctl_pkg::sample_t'({1'b0, mag});
    end

endmodule

`default_nettype wire

FILE: rtl/sine_cosine_turn_lut_core.sv
// Top level of the sine/cosine table core: input register, two phase evaluators, result register.
// Depends on sctl_pkg, sctl_phase and sine_cosine_turn_lut_core_defines.svh.
//
//  channel | beat signals          | fields        | side
//  --------+-----------------------+---------------+--------------------------
//  src     | src_valid, src_stall  | angle[15:0]   | angle in, 65536 = 1 turn
//  res     | res_valid, res_stall  | sine, cosine  | signed Q1.16 results out
//
// One beat is taken every cycle while src_stall is low; the angle is registered, then the result.
// The only work is two table reads and one 17x14 multiply per output between two registers.
// A stalled result holds in the output register while the input register still fills.
// rst_n clears the valid flags only; the data registers need no reset.
`default_nettype none
`include "sine_cosine_turn_lut_core_defines.svh"

module sine_cosine_turn_lut_core (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    src_valid,
    output logic                   src_stall,
    input  wire sctl_pkg::angle_t  angle,
    output logic                   res_valid,
    input  wire                    res_stall,
    output sctl_pkg::sample_t      sine,
    output sctl_pkg::sample_t      cosine
);

    logic               stage_valid_reg;
    logic               stage_valid_next;
    sctl_pkg::angle_t   angle_reg;
    logic               res_valid_reg;
    logic               res_valid_next;
    sctl_pkg::sample_t  sine_reg;
    sctl_pkg::sample_t  cosine_reg;
    sctl_pkg::angle_t   cos_angle;
    sctl_pkg::sample_t  sine_val;
    sctl_pkg::sample_t  cosine_val;
    logic               res_open;
    logic               stage_move;
    logic               src_take;
    logic               sine_in_range;
    logic               cosine_in_range;

    // Handshake: the result register opens when empty or drained this cycle
    always_comb
    begin
        res_open         = !res_valid_reg || !res_stall;
        stage_move       = stage_valid_reg && res_open;
        src_stall        = stage_valid_reg && !res_open;
        src_take         = src_valid && !src_stall;
        stage_valid_next = src_take || (stage_valid_reg && !res_open);
        res_valid_next   = stage_move || (res_valid_reg && !res_open);
    end

    // Valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            res_valid_reg   <= res_valid_next;
        end
    end

    // Capture the angle on an accepted beat
    always_ff @(posedge clk)
    begin
        if (src_take)
            angle_reg <= angle;
    end

    // Cosine is the sine a quarter turn ahead, wrapping at one turn
    assign cos_angle = angle_reg + sctl_pkg::QUARTER_ANGLE;

    sctl_phase u_sine (
        .angle (angle_reg),
        .value (sine_val)
    );

    sctl_phase u_cosine (
        .angle (cos_angle),
        .value (cosine_val)
    );

    // Load results when the stage advances, hold them while stalled
    always_ff @(posedge clk)
    begin
        if (stage_move)
        begin
            sine_reg   <= sine_val;
            cosine_reg <= cosine_val;
        end
    end

    assign res_valid = res_valid_reg;
    assign sine      = sine_reg;
    assign cosine    = cosine_reg;

    // Flag results that sit within plus or minus full scale
    always_comb
    begin
        sine_in_range   = (sine_reg <= sctl_pkg::FULL_SCALE)
                       && (sine_reg >= -sctl_pkg::FULL_SCALE);
        cosine_in_range = (cosine_reg <= sctl_pkg::FULL_SCALE)
                       && (cosine_reg >= -sctl_pkg::FULL_SCALE);
    end

    // A held input stage keeps its angle until it moves on
    `SCTL_ASSERT(a_stage_hold, src_stall |=> (stage_valid_reg && $stable(angle_reg)), "beat moved")
    // Every beat that leaves the input stage lands in the result register
    `SCTL_ASSERT(a_stage_to_res, stage_move |=> res_valid_reg, "stage beat lost")
    // An accepted beat always occupies the input stage next cycle
    `SCTL_ASSERT(a_take_fills, src_take |=> stage_valid_reg, "accepted angle lost")
    // Results stay within plus or minus full scale
    `SCTL_ASSERT(a_range, res_valid_reg |-> sine_in_range && cosine_in_range, "out of range")

endmodule

`default_nettype wire
